// ===== design/bsf_pkg.sv =====
// Shared types and constants for the banned substring filter.
// Holds the banned word table used by the matcher.
// No dependencies.
package bsf_pkg;

    // Item kinds carried on the input tuser bit.
    typedef enum logic
    {
        KIND_BYTE = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned WINDOW_LEN  = 7;
    localparam int unsigned WINDOW_W    = WINDOW_LEN * CHAR_W;
    localparam int unsigned SEQ_W       = WINDOW_W + CHAR_W;
    localparam int unsigned WORD_SLOTS  = 8;
    localparam int unsigned COUNT_W     = 13;
    localparam int unsigned LENGTH_W    = 12;

    localparam logic [COUNT_W-1:0]  COUNT_LIMIT       = {COUNT_W{1'b1}};
    localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET  = 12'd280;

    // Each word is right-aligned: its last character sits in the lowest byte,
    // which lines up with the newest byte of the window sequence.
    localparam logic [SEQ_W-1:0] WORD_TAIL [WORD_SLOTS] = '{
        64'h0000_414C_5041_4341,
        64'h0000_6170_696B_6579,
        64'h0061_7069_5F6B_6579,
        64'h0061_7069_2D6B_6579,
        64'h0000_7365_6372_6574,
        64'h0000_0074_6F6B_656E,
        64'h7061_7373_776F_7264,
        64'h0042_6561_7265_7220
    };

    // Byte mask covering the length of each word.
    localparam logic [SEQ_W-1:0] WORD_MASK [WORD_SLOTS] = '{
        64'h0000_FFFF_FFFF_FFFF,
        64'h0000_FFFF_FFFF_FFFF,
        64'h00FF_FFFF_FFFF_FFFF,
        64'h00FF_FFFF_FFFF_FFFF,
        64'h0000_FFFF_FFFF_FFFF,
        64'h0000_00FF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h00FF_FFFF_FFFF_FFFF
    };

endpackage

// ===== design/bsf_word_match.sv =====
// Combinational compare of the byte window plus the newest byte against
// the banned word table.
// Depends on bsf_pkg.
module bsf_word_match
(
    input  logic [bsf_pkg::WINDOW_W-1:0] window,
    input  logic [bsf_pkg::CHAR_W-1:0]   fresh,
    output logic                         hit
);

    logic [bsf_pkg::SEQ_W-1:0]      seq;
    logic [bsf_pkg::WORD_SLOTS-1:0] slot_hit;

    assign seq = {window, fresh};

    // One independent masked compare per banned word.
    always_comb
    begin
        for (int w = 0; w < bsf_pkg::WORD_SLOTS; w++)
        begin
            slot_hit[w] = ((seq ^ bsf_pkg::WORD_TAIL[w]) & bsf_pkg::WORD_MASK[w])
                          == '0;
        end
    end

    assign hit = |slot_hit;

endmodule

// ===== design/bsf_out_reg.sv =====
// Result register for the verdict stream.
// Holds one verdict until the downstream side takes it.
// Depends on no package items.
module bsf_out_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       result_valid,
    input  logic       result_accepted,
    output logic       load_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // [0] accepted, [7:1] zero
);

    logic m_tvalid_reg;
    logic m_tvalid_next;
    logic accepted_reg;

    // The register can take a new verdict when empty or being drained.
    assign load_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        if (result_valid && load_ready)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (result_valid && load_ready)
        begin
            accepted_reg <= result_accepted;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, accepted_reg};

endmodule

// ===== design/banned_substring_filter_core.sv =====
// Top level of the banned substring filter: input register, message state,
// word matcher and verdict register.
// Depends on bsf_pkg, bsf_word_match and bsf_out_reg.
//
// The filter takes one request per clock cycle unless stalled: message bytes
// with tuser low and an end marker with tuser high. Each byte is checked against
// the banned word table in a single compare stage sitting between the input
// register and the message state, so a steady stream runs at one byte per cycle.
// The end marker passes from the input register into the verdict register,
// which raises one verdict on the master side; a byte produces nothing. The
// input side stalls only while an end marker waits for the verdict register to
// free up. max_length may be written on the cfg channel at any time the filter
// is idle and is always ready.
module banned_substring_filter_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] char_code
    input  logic                           s_tuser,   // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [0] accepted, [7:1] zero
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bsf_pkg::LENGTH_W-1:0]   cfg_data
);

    logic                           in_valid_reg;
    logic                           in_valid_next;
    bsf_pkg::kind_t                 in_kind_reg;
    logic [bsf_pkg::CHAR_W-1:0]     in_char_reg;

    logic [bsf_pkg::WINDOW_W-1:0]   recent_bytes_reg;
    logic [bsf_pkg::WINDOW_W-1:0]   recent_bytes_next;
    logic [bsf_pkg::COUNT_W-1:0]    byte_count_reg;
    logic [bsf_pkg::COUNT_W-1:0]    byte_count_next;
    logic                           word_found_reg;
    logic                           word_found_next;
    logic [bsf_pkg::LENGTH_W-1:0]   max_length_reg;

    logic                           s_accept;
    logic                           stage_fire;
    logic                           load_ready;
    logic                           hit;
    logic                           verdict_valid;
    logic                           verdict_ok;

    // Configuration register, always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= bsf_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_length_reg <= cfg_data;
        end
    end

    // Stage handshake: bytes always advance, an end marker needs the
    // verdict register.
    assign stage_fire = in_valid_reg &&
                        ((in_kind_reg == bsf_pkg::KIND_BYTE) || load_ready);
    assign s_tready   = !in_valid_reg || stage_fire;
    assign s_accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (stage_fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_kind_reg <= bsf_pkg::kind_t'(s_tuser);
            in_char_reg <= s_tdata;
        end
    end

    bsf_word_match u_match
    (
        .window (recent_bytes_reg),
        .fresh  (in_char_reg),
        .hit    (hit)
    );

    // Message state update: shift and count on a byte, clear on the end marker.
    always_comb
    begin
        recent_bytes_next = recent_bytes_reg;
        byte_count_next   = byte_count_reg;
        word_found_next   = word_found_reg;
        if (stage_fire)
        begin
            if (in_kind_reg == bsf_pkg::KIND_END)
            begin
                recent_bytes_next = '0;
                byte_count_next   = '0;
                word_found_next   = 1'b0;
            end
            else
            begin
                recent_bytes_next = {recent_bytes_reg[bsf_pkg::WINDOW_W-bsf_pkg::CHAR_W-1:0],
                                     in_char_reg};
                if (byte_count_reg != bsf_pkg::COUNT_LIMIT)
                begin
                    byte_count_next = byte_count_reg + 1'b1;
                end
                word_found_next = word_found_reg | hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_bytes_reg <= '0;
            byte_count_reg   <= '0;
            word_found_reg   <= 1'b0;
        end
        else
        begin
            recent_bytes_reg <= recent_bytes_next;
            byte_count_reg   <= byte_count_next;
            word_found_reg   <= word_found_next;
        end
    end

    // Verdict from the state accumulated before the end marker.
    assign verdict_valid = stage_fire && (in_kind_reg == bsf_pkg::KIND_END);
    assign verdict_ok    = (byte_count_reg <= {1'b0, max_length_reg}) && !word_found_reg;

    bsf_out_reg u_out
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .result_valid    (verdict_valid),
        .result_accepted (verdict_ok),
        .load_ready      (load_ready),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

`ifndef ASSERT_OFF
    // A byte below saturation raises the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && (in_kind_reg == bsf_pkg::KIND_BYTE) &&
         (byte_count_reg != bsf_pkg::COUNT_LIMIT))
        |=> (byte_count_reg == $past(byte_count_reg) + 1'b1))
        else $error("byte count did not advance on a message byte");

    // The end marker leaves the message state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |=> ((byte_count_reg == '0) && !word_found_reg &&
                           (recent_bytes_reg == '0)))
        else $error("message state not cleared after verdict");

    // The hit flag only drops at the end marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        (word_found_reg && !verdict_valid) |=> word_found_reg)
        else $error("hit flag lost inside a message");

    // A stalled end marker stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (in_kind_reg == bsf_pkg::KIND_END) && !load_ready)
        |=> (in_valid_reg && (in_kind_reg == bsf_pkg::KIND_END)))
        else $error("stalled end marker dropped");
`endif

endmodule

// ===== bench/banned_substring_filter_core_test.sv =====
// Self-checking testbench for banned_substring_filter_core: streams text messages through
// the filter and compares every verdict with an in-bench prediction of the screening rules.
// Depends on bsf_pkg and the design files; needs no input files.
module banned_substring_filter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLOCK_HALF    = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_QUOTA   = 160;

    // Tracks one message at a time and queues the verdict each end marker should give.
    class verdict_board;
        logic [bsf_pkg::LENGTH_W-1:0] max_len;
        logic [bsf_pkg::WINDOW_W-1:0] window;
        logic [bsf_pkg::COUNT_W-1:0]  count;
        bit                           found;
        bit                           verdicts[$];
        string                        words[bsf_pkg::WORD_SLOTS];
        int                           mismatches;

        function new();
            words[0] = "A";
            words[0] = {words[0], "LPACA"};
            words[1] = "apikey";
            words[2] = "api_key";
            words[3] = "api-key";
            words[4] = "secret";
            words[5] = "token";
            words[6] = "password";
            words[7] = "Bearer ";
            max_len = bsf_pkg::MAX_LENGTH_RESET;
            mismatches = 0;
            clear_message();
        endfunction

        function void clear_message();
            window = '0;
            count = '0;
            found = 1'b0;
        endfunction

        function void set_max_len(logic [bsf_pkg::LENGTH_W-1:0] value);
            max_len = value;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        // Updates the message state for one accepted request.
        function void note_request(bsf_pkg::kind_t kind, logic [7:0] code);
            logic [bsf_pkg::WINDOW_W+7:0] seq;
            int                           len;
            int                           k;
            bit                           hit;
            if (kind == bsf_pkg::KIND_END)
            begin
                verdicts.push_back((count <= max_len) && !found);
                clear_message();
                return;
            end
            seq = {window, code};
            foreach (words[w])
            begin
                len = words[w].len();
                hit = 1'b1;
                for (k = 0; k < len; k++)
                begin
                    if (seq[8*k +: 8] != words[w][len-1-k])
                        hit = 1'b0;
                end
                if (hit)
                    found = 1'b1;
            end
            window = seq[bsf_pkg::WINDOW_W-1:0];
            if (count != bsf_pkg::COUNT_LIMIT)
                count++;
        endfunction

        // Compares one delivered verdict with the oldest one waiting.
        function void check_verdict(logic [7:0] data);
            bit want;
            if (verdicts.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected verdict %0d with no message pending", data[0]);
                mismatches++;
                return;
            end
            want = verdicts.pop_front();
            if (data[0] !== want)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("verdict mismatch: expected accepted=%0d, got %0d", want, data[0]);
                mismatches++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [7:0]                   s_tdata;   // [7:0] char_code
    logic                         s_tuser;   // [0] kind
    logic                         m_tvalid;
    logic                         m_tready;
    logic [7:0]                   m_tdata;   // [0] accepted, [7:1] zero
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [bsf_pkg::LENGTH_W-1:0] cfg_data;

    verdict_board board = new();
    logic [7:0]   text_q[$];
    string        letter_pool = "apiyeklPACsrctonwdB _-";
    int           items_sent = 0;
    int           idle_cycles = 0;
    bit           quiet_send = 1'b0;
    bit           quiet_recv = 1'b0;
    bit           hold_output = 1'b0;

    banned_substring_filter_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLOCK_HALF clk = ~clk;
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    // Offers one request and waits until the filter takes it.
    task automatic send_item(input bsf_pkg::kind_t kind, input logic [7:0] code);
        int gap;
        gap = draw_wait(quiet_send);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        board.note_request(kind, code);
        items_sent++;
    endtask

    function automatic void add_string(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    // Sends the queued text followed by an end marker.
    task automatic finish_message(input logic [7:0] end_code);
        foreach (text_q[i])
            send_item(bsf_pkg::KIND_BYTE, text_q[i]);
        send_item(bsf_pkg::KIND_END, end_code);
        text_q.delete();
    endtask

    // Fills the text queue with exactly target bytes. Clean text holds only random
    // bytes and near misses; the rest also carries whole words, prefixes and suffixes.
    function automatic void build_random_text(int target, bit clean);
        string w;
        int    pick;
        int    pos;
        text_q.delete();
        while (text_q.size() < target)
        begin
            pick = clean ? $urandom_range(0, 4) : $urandom_range(0, 9);
            w = board.words[$urandom_range(0, bsf_pkg::WORD_SLOTS - 1)];
            case (pick)
                0, 1: text_q.push_back(8'($urandom_range(0, 255)));
                2: text_q.push_back(letter_pool[$urandom_range(0, letter_pool.len() - 1)]);
                3:
                begin
                    // Same word with one character in the other case.
                    pos = $urandom_range(0, w.len() - 1);
                    if (w[pos] == " ")
                        w[pos] = "_";
                    else
                        w[pos] = w[pos] ^ 8'h20;
                    add_string(w);
                end
                4: add_string(w.substr(0, w.len() - 2));
                6: add_string(w.substr(1, w.len() - 1));
                7:
                begin
                    w[w.len() - 1] = w[w.len() - 1] + 8'd1;
                    add_string(w);
                end
                default: add_string(w);
            endcase
        end
        while (text_q.size() > target)
            void'(text_q.pop_back());
    endfunction

    function automatic int pick_length(logic [bsf_pkg::LENGTH_W-1:0] limit);
        int r;
        int len;
        r = $urandom_range(0, 19);
        if (r < 2 && limit <= 300)
        begin
            len = int'(limit) + $urandom_range(0, 2) - 1;
            return (len < 0) ? 0 : len;
        end
        if (r < 3)
            return $urandom_range(25, 60);
        return $urandom_range(0, 20);
    endfunction

    // Waits until every verdict is in and the pipeline has drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [bsf_pkg::LENGTH_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_max_len(value);
    endtask

    // One setting of max_length with random messages, sometimes leaving a
    // message open so that it continues under the next setting.
    task automatic run_phase(input logic [bsf_pkg::LENGTH_W-1:0] limit, input int quota);
        int first;
        settle();
        write_max_length(limit);
        first = items_sent;
        while (items_sent - first < quota)
        begin
            if ($urandom_range(0, 15) == 0)
                quiet_send = !quiet_send;
            if ($urandom_range(0, 15) == 0)
                quiet_recv = !quiet_recv;
            build_random_text(pick_length(limit), $urandom_range(0, 1));
            finish_message(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            build_random_text($urandom_range(1, 6), 1'b0);
            foreach (text_q[i])
                send_item(bsf_pkg::KIND_BYTE, text_q[i]);
            text_q.delete();
        end
    endtask

    // Verdict receiver with random back-pressure and one long hold on request.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            if (hold_output)
            begin
                hold_output = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = draw_wait(quiet_recv);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_verdict(m_tdata);
        end
    end

    // Watchdog on cycles without any handshake.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed messages, random phases and pressure.
    initial
    begin
        int n;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= bsf_pkg::KIND_BYTE;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message; the code beside an end marker is ignored.
        finish_message(8'hFF);
        add_string("token");
        finish_message(8'h00);
        // Zero and high bytes count as ordinary text.
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        finish_message(8'h5A);
        // Longest word fills the whole window plus the newest byte.
        add_string("password");
        finish_message(8'hA5);
        // Missing trailing space is not a match.
        add_string("Bearer!");
        finish_message(8'h01);

        // Random phases over several length limits, extremes included.
        run_phase(12'd0, PHASE_QUOTA);
        run_phase(12'd1, PHASE_QUOTA);
        run_phase(bsf_pkg::MAX_LENGTH_RESET, PHASE_QUOTA);
        run_phase(12'd4095, PHASE_QUOTA);
        run_phase(12'($urandom_range(2, 30)), PHASE_QUOTA);
        run_phase(12'($urandom_range(2, 30)), PHASE_QUOTA);
        run_phase(12'($urandom_range(2, 30)), PHASE_QUOTA);
        run_phase(12'($urandom_range(31, 300)), PHASE_QUOTA);
        run_phase(12'($urandom_range(0, 4095)), PHASE_QUOTA);

        // Output held off while short messages keep arriving back to back.
        settle();
        write_max_length(12'd2);
        quiet_send = 1'b1;
        hold_output = 1'b1;
        for (n = 0; n < 60; n++)
        begin
            build_random_text($urandom_range(0, 3), $urandom_range(0, 1));
            finish_message(8'($urandom_range(0, 255)));
        end
        quiet_send = 1'b0;

        settle();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
